[design/refrigerant_pressure_to_temp_top_macros.svh]
// assertion macros for the pressure to temperature block
`ifndef REFRIGERANT_PRESSURE_TO_TEMP_TOP_MACROS_SVH
`define REFRIGERANT_PRESSURE_TO_TEMP_TOP_MACROS_SVH

// same-cycle implication
`define RPTT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rptt check failed");

// next-cycle implication
`define RPTT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rptt check failed");

`endif

[design/rptt_pkg.sv]
package rptt_pkg;

    localparam int POINTS = 34;
    localparam int NGAS   = 3;
    localparam int P_W    = 21;
    localparam int T_W    = 18;
    localparam int TAB_W  = 17;
    localparam int T_STEP = 5000;
    localparam int QW     = $clog2(T_STEP + 1);
    localparam int PW     = TAB_W + QW;
    localparam int CNT_W  = $clog2(QW + 1);
    localparam int IDX_W  = $clog2(POINTS);
    localparam int AW     = $clog2(NGAS * POINTS);
    localparam int DEPTH  = NGAS * POINTS;

    localparam int T_FIRST = -70000;
    localparam int T_LAST  = T_FIRST + T_STEP * (POINTS - 1);

    localparam logic signed [T_W-1:0] T_FIRST_W = T_W'(T_FIRST);
    localparam logic signed [T_W-1:0] T_LAST_W  = T_W'(T_LAST);
    localparam logic signed [T_W-1:0] T_STEP_W  = T_W'(T_STEP);

    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_LOW  = 2'd1,
        STAT_HIGH = 2'd2,
        STAT_GAS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_FIRST,
        ST_SCAN,
        ST_DIV,
        ST_WR
    } t_state;

    // gas tables back to back: r32, r134a, r507
    localparam logic [TAB_W-1:0] TAB [DEPTH] = '{
        17'd360,   17'd490,   17'd650,   17'd850,   17'd1100,  17'd1410,
        17'd1770,  17'd2210,  17'd2730,  17'd3350,  17'd4060,  17'd4880,
        17'd5830,  17'd6910,  17'd8130,  17'd9510,  17'd11070, 17'd12810,
        17'd14750, 17'd16900, 17'd19280, 17'd21900, 17'd24780, 17'd27950,
        17'd31410, 17'd35200, 17'd39330, 17'd43840, 17'd48770, 17'd55000,
        17'd65000, 17'd75000, 17'd85000, 17'd95000,
        17'd0,     17'd0,     17'd0,     17'd0,     17'd300,   17'd390,
        17'd510,   17'd660,   17'd840,   17'd1060,  17'd1330,  17'd1640,
        17'd2010,  17'd2430,  17'd2930,  17'd3500,  17'd4150,  17'd4880,
        17'd5720,  17'd6650,  17'd7700,  17'd8870,  17'd10170, 17'd11600,
        17'd13180, 17'd14920, 17'd16820, 17'd18900, 17'd21170, 17'd23640,
        17'd26330, 17'd29260, 17'd32440, 17'd35910,
        17'd280,   17'd380,   17'd510,   17'd660,   17'd860,   17'd1100,
        17'd1390,  17'd1770,  17'd2130,  17'd2600,  17'd3150,  17'd3750,
        17'd4500,  17'd5310,  17'd6240,  17'd7220,  17'd8460,  17'd9780,
        17'd11220, 17'd12800, 17'd14600, 17'd16520, 17'd18700, 17'd22010,
        17'd23610, 17'd26420, 17'd29490, 17'd32850, 17'd36560, 17'd40000,
        17'd50000, 17'd60000, 17'd70000, 17'd80000
    };

    function automatic logic [AW-1:0] rom_addr(input logic [1:0] mode,
                                               input logic [IDX_W:0] idx);
        rom_addr = AW'(AW'(mode) * AW'(POINTS) + AW'(idx));
    endfunction

    function automatic logic signed [P_W-1:0] tab_ext(input logic [TAB_W-1:0] v);
        tab_ext = signed'({{(P_W-TAB_W){1'b0}}, v});
    endfunction

endpackage

[design/rptt_rom.sv]
module rptt_rom (
    input  logic                          i_clk,
    input  logic [rptt_pkg::AW-1:0]       i_addr,
    output logic [rptt_pkg::TAB_W-1:0]    o_data
);

    logic [rptt_pkg::TAB_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (32'(i_addr) < 32'(rptt_pkg::DEPTH)) begin
            r_data <= rptt_pkg::TAB[i_addr];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

[design/rptt_div.sv]
module rptt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rptt_pkg::TAB_W-1:0]    i_num,
    input  logic [rptt_pkg::TAB_W-1:0]    i_den,
    output logic                          o_done,
    output logic [rptt_pkg::QW-1:0]       o_quot
);

    logic                          r_busy;
    logic                          r_mul;
    logic                          r_done;
    logic [rptt_pkg::CNT_W-1:0]    r_cnt;
    logic [rptt_pkg::TAB_W-1:0]    r_num;
    logic [rptt_pkg::TAB_W-1:0]    r_den;
    logic [rptt_pkg::TAB_W-1:0]    r_rem;
    logic [rptt_pkg::QW-1:0]       r_dvd;
    logic [rptt_pkg::QW-1:0]       r_q;

    logic [rptt_pkg::PW-1:0]       prod;
    logic [rptt_pkg::TAB_W:0]      trial;
    logic                          fits;

    assign prod  = rptt_pkg::PW'(rptt_pkg::T_STEP) * rptt_pkg::PW'(r_num);
    assign trial = {r_rem, r_dvd[rptt_pkg::QW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_mul) begin
                r_mul <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + rptt_pkg::CNT_W'(1);
                if (r_cnt == rptt_pkg::CNT_W'(rptt_pkg::QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy && r_mul) begin
            r_rem <= prod[rptt_pkg::PW-1:rptt_pkg::QW];
            r_dvd <= prod[rptt_pkg::QW-1:0];
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= rptt_pkg::TAB_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[rptt_pkg::TAB_W-1:0];
            end
            r_dvd <= {r_dvd[rptt_pkg::QW-2:0], 1'b0};
            r_q   <= {r_q[rptt_pkg::QW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[design/refrigerant_pressure_to_temp_top.sv]
// sequence: an unsupported gas goes straight to the write state; else the last and first
// table points are read and a clamped reading goes to the write state, an exact hit on the
// last point ends the one-entry-per-cycle table scan at the last temperature, and a reading
// in segment k (up to 32) ends the scan there and is interpolated by the 13-step divider
// input: a new word is taken once the last result is queued in the output register
// reset: synchronous active-low i_rst_n empties the sequencer and the output register
`include "refrigerant_pressure_to_temp_top_macros.svh"

module refrigerant_pressure_to_temp_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_mode,
    input  logic signed [rptt_pkg::P_W-1:0]    i_pressure,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [rptt_pkg::T_W-1:0]    o_temperature,
    output logic [1:0]                         o_status
);

    rptt_pkg::t_state                      r_state;
    rptt_pkg::t_state                      n_state;
    logic [1:0]                            r_mode;
    logic signed [rptt_pkg::P_W-1:0]       r_p;
    logic [rptt_pkg::TAB_W-1:0]            r_last;
    logic [rptt_pkg::TAB_W-1:0]            r_lo;
    logic [rptt_pkg::IDX_W-1:0]            r_k;
    logic signed [rptt_pkg::T_W-1:0]       r_base;
    logic signed [rptt_pkg::T_W-1:0]       r_res_t;
    rptt_pkg::t_status                     r_res_s;
    logic                                  r_out_valid;
    logic signed [rptt_pkg::T_W-1:0]       r_out_t;
    rptt_pkg::t_status                     r_out_s;

    logic [rptt_pkg::AW-1:0]               rom_addr;
    logic [rptt_pkg::TAB_W-1:0]            rom_data;
    logic                                  in_rdy;
    logic                                  div_start;
    logic                                  div_done;
    logic [rptt_pkg::QW-1:0]               div_quot;
    logic [rptt_pkg::TAB_W-1:0]            div_num;
    logic [rptt_pkg::TAB_W-1:0]            div_den;

    logic                                  accept;
    logic                                  out_free;
    logic                                  clamp_low;
    logic                                  clamp_high;
    logic                                  hit;
    logic                                  at_end;
    logic signed [rptt_pkg::P_W-1:0]       lo_ext;
    logic signed [rptt_pkg::P_W-1:0]       d_ext;

    rptt_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    rptt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign accept     = i_valid && in_rdy;
    assign out_free   = !r_out_valid || i_ready;
    assign d_ext      = rptt_pkg::tab_ext(rom_data);
    assign lo_ext     = rptt_pkg::tab_ext(r_lo);
    assign clamp_low  = (r_p < 0) || (r_p < d_ext);
    assign clamp_high = r_p > rptt_pkg::tab_ext(r_last);
    assign hit        = (lo_ext <= r_p) && (r_p < d_ext);
    assign at_end     = (r_k + rptt_pkg::IDX_W'(1)) == rptt_pkg::IDX_W'(rptt_pkg::POINTS - 1);
    assign div_num    = rptt_pkg::TAB_W'(r_p - lo_ext);
    assign div_den    = rom_data - r_lo;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rptt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_mode == rptt_pkg::MODE_NONE) ? rptt_pkg::ST_WR
                                                              : rptt_pkg::ST_LAST;
                end
            end
            rptt_pkg::ST_LAST: begin
                n_state = rptt_pkg::ST_FIRST;
            end
            rptt_pkg::ST_FIRST: begin
                n_state = (clamp_low || clamp_high) ? rptt_pkg::ST_WR : rptt_pkg::ST_SCAN;
            end
            rptt_pkg::ST_SCAN: begin
                if (hit) begin
                    n_state = rptt_pkg::ST_DIV;
                end else if (at_end) begin
                    n_state = rptt_pkg::ST_WR;
                end
            end
            rptt_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = rptt_pkg::ST_WR;
                end
            end
            rptt_pkg::ST_WR: begin
                if (out_free) begin
                    n_state = rptt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rptt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_rdy    = 1'b0;
        div_start = 1'b0;
        rom_addr  = '0;
        case (r_state)
            rptt_pkg::ST_IDLE: begin
                in_rdy   = 1'b1;
                rom_addr = rptt_pkg::rom_addr(i_mode,
                                              (rptt_pkg::IDX_W+1)'(rptt_pkg::POINTS - 1));
            end
            rptt_pkg::ST_LAST: begin
                rom_addr = rptt_pkg::rom_addr(r_mode, '0);
            end
            rptt_pkg::ST_FIRST: begin
                rom_addr = rptt_pkg::rom_addr(r_mode, (rptt_pkg::IDX_W+1)'(1));
            end
            rptt_pkg::ST_SCAN: begin
                div_start = hit;
                rom_addr  = rptt_pkg::rom_addr(r_mode,
                                               {1'b0, r_k} + (rptt_pkg::IDX_W+1)'(2));
            end
            default: begin
                rom_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rptt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rptt_pkg::ST_WR && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rptt_pkg::ST_IDLE: begin
                if (accept) begin
                    r_mode  <= i_mode;
                    r_p     <= i_pressure;
                    r_res_t <= '0;
                    r_res_s <= rptt_pkg::STAT_GAS;
                end
            end
            rptt_pkg::ST_LAST: begin
                r_last <= rom_data;
            end
            rptt_pkg::ST_FIRST: begin
                r_lo   <= rom_data;
                r_k    <= '0;
                r_base <= rptt_pkg::T_FIRST_W;
                if (clamp_low) begin
                    r_res_t <= rptt_pkg::T_FIRST_W;
                    r_res_s <= rptt_pkg::STAT_LOW;
                end else if (clamp_high) begin
                    r_res_t <= rptt_pkg::T_LAST_W;
                    r_res_s <= rptt_pkg::STAT_HIGH;
                end
            end
            rptt_pkg::ST_SCAN: begin
                if (!hit) begin
                    r_lo   <= rom_data;
                    r_k    <= r_k + rptt_pkg::IDX_W'(1);
                    r_base <= r_base + rptt_pkg::T_STEP_W;
                    if (at_end) begin
                        r_res_t <= rptt_pkg::T_LAST_W;
                        r_res_s <= rptt_pkg::STAT_OK;
                    end
                end
            end
            rptt_pkg::ST_DIV: begin
                if (div_done) begin
                    r_res_t <= r_base + signed'({{(rptt_pkg::T_W-rptt_pkg::QW){1'b0}},
                                                 div_quot});
                    r_res_s <= rptt_pkg::STAT_OK;
                end
            end
            rptt_pkg::ST_WR: begin
                if (out_free) begin
                    r_out_t <= r_res_t;
                    r_out_s <= r_res_s;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_ready       = in_rdy;
    assign o_valid       = r_out_valid;
    assign o_temperature = r_out_t;
    assign o_status      = r_out_s;

    `RPTT_ASSERT_IMP(a_gas_zero, o_valid && o_status == rptt_pkg::STAT_GAS, o_temperature == '0)
    `RPTT_ASSERT_IMP(a_low_value, o_valid && o_status == rptt_pkg::STAT_LOW, o_temperature == rptt_pkg::T_FIRST_W)
    `RPTT_ASSERT_IMP(a_div_in_state, div_done, r_state == rptt_pkg::ST_DIV)
    `RPTT_ASSERT_NXT(a_busy_after_word, i_valid && o_ready, !o_ready)

endmodule
